>>> rtl/core/tok_pkg.sv
// Package for the tag overlap top-k core: sizes, widths, command codes and state encoding.
// No dependencies; the core, the checker and the testbench use it by scoped names.
`timescale 1ns / 1ps
package tok_pkg;

  localparam int unsigned QUERY_TAGS = 64;
  localparam int unsigned TOP_K      = 64;

  localparam int unsigned QAW = (QUERY_TAGS > 1) ? $clog2(QUERY_TAGS) : 1;
  localparam int unsigned QFW = $clog2(QUERY_TAGS + 1);
  localparam int unsigned TAW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int unsigned TFW = $clog2(TOP_K + 1);

  localparam int unsigned TAG_W   = 34;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned ENTRY_W = ID_W + CNT_W;
  localparam int unsigned MAXC_W  = 7;

  localparam logic [MAXC_W-1:0] MAX_COUNT_RST = 7'd10;
  localparam logic [CNT_W-1:0]  CNT_SAT       = 8'd255;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CAND   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_e;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN_RD  = 8'b0000_0010,
    S_SCAN_CMP = 8'b0000_0100,
    S_INS_RD   = 8'b0000_1000,
    S_INS_CMP  = 8'b0001_0000,
    S_FIN_RD   = 8'b0010_0000,
    S_FIN_OUT  = 8'b0100_0000,
    S_SPARE    = 8'b1000_0000
  } state_e;

endpackage

>>> rtl/core/tok_if.sv
// Valid/ready channel interfaces for the input beats and the result beats.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps
interface tok_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] entity_id;
  logic [1:0]  tag_kind;
  logic [31:0] tag_key;
  logic        last_tag;

  modport source (output valid, cmd, entity_id, tag_kind, tag_key, last_tag, input ready);
  modport sink   (input valid, cmd, entity_id, tag_kind, tag_key, last_tag, output ready);
endinterface

interface tok_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_id;
  logic [7:0]  overlap_count;
  logic        result_valid;
  logic        last_result;

  modport source (output valid, result_id, overlap_count, result_valid, last_result,
                  input ready);
  modport sink   (input valid, result_id, overlap_count, result_valid, last_result,
                  output ready);
endinterface

>>> rtl/core/tok_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module tok_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 34,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/tag_overlap_top_k_core.sv
// Tag overlap top-k core: query set and ranked list live in two RAMs with registered reads.
// Query and candidate beats scan the query entries; a closing candidate also shifts list
// entries to make room; finish sends nothing if max_count is 0, else the empty marker
// or one result beat per entry, and waits while the sink stalls.
// Throughput: one beat at a time, set by the single read port of each RAM.
// Reset (rst_ni low, asynchronous) empties both fills, clears the count and sets max_count 10.
`timescale 1ns / 1ps
module tag_overlap_top_k_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tok_pkg::MAXC_W-1:0] cfg_wdata_i,
  tok_in_if.sink                     in_i,
  tok_out_if.source                  out_o
);

  // Control and bookkeeping registers. The RAM contents themselves are never reset:
  // only entries below the fill counts are ever read.
  tok_pkg::state_e state_q, state_d;
  logic [1:0]                  cmd_q;
  logic [tok_pkg::ID_W-1:0]    id_q;
  logic [tok_pkg::TAG_W-1:0]   tag_q;
  logic                        last_q;
  logic [tok_pkg::QFW-1:0]     qfill_q, qfill_d;
  logic [tok_pkg::QFW-1:0]     idx_q, idx_d;
  logic [tok_pkg::ID_W-1:0]    excl_q, excl_d;
  logic [tok_pkg::CNT_W-1:0]   run_q, run_d;
  logic [tok_pkg::TFW-1:0]     tfill_q, tfill_d;
  logic [tok_pkg::TFW-1:0]     ins_q, ins_d;
  logic [tok_pkg::CNT_W-1:0]   icnt_q, icnt_d;
  logic [tok_pkg::TFW-1:0]     fin_n_q, fin_n_d;
  logic [tok_pkg::TFW-1:0]     fin_k_q, fin_k_d;
  logic [tok_pkg::MAXC_W-1:0]  max_q;

  // Output register: holds a result beat until the sink takes it.
  logic                        ovalid_q, ovalid_d;
  logic [tok_pkg::ID_W-1:0]    oid_q, oid_d;
  logic [tok_pkg::CNT_W-1:0]   ocnt_q, ocnt_d;
  logic                        orv_q, orv_d;
  logic                        olast_q, olast_d;
  logic                        out_free;

  // RAM ports.
  logic                          q_we;
  logic [tok_pkg::QAW-1:0]       q_waddr, q_raddr;
  logic [tok_pkg::TAG_W-1:0]     q_rdata;
  logic                          t_we;
  logic [tok_pkg::TAW-1:0]       t_waddr, t_raddr;
  logic [tok_pkg::ENTRY_W-1:0]   t_wdata, t_rdata;

  logic                          in_acc;
  logic                          hit_now;
  logic                          scan_end;
  logic [tok_pkg::CNT_W-1:0]     run_new;
  logic [tok_pkg::MAXC_W-1:0]    max_lim;
  logic [tok_pkg::TFW-1:0]       n_lim;
  logic [tok_pkg::TFW-1:0]       ins_m1;
  logic [tok_pkg::TFW-1:0]       tfill_inc;

  tok_ram #(
    .DEPTH(tok_pkg::QUERY_TAGS), .WIDTH(tok_pkg::TAG_W), .AW(tok_pkg::QAW)
  ) u_qram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(tag_q),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  tok_ram #(
    .DEPTH(tok_pkg::TOP_K), .WIDTH(tok_pkg::ENTRY_W), .AW(tok_pkg::TAW)
  ) u_tram (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  assign in_i.ready    = (state_q == tok_pkg::S_IDLE);
  assign in_acc        = in_i.valid && in_i.ready;
  assign out_free      = !ovalid_q || out_o.ready;

  assign out_o.valid         = ovalid_q;
  assign out_o.result_id     = oid_q;
  assign out_o.overlap_count = ocnt_q;
  assign out_o.result_valid  = orv_q;
  assign out_o.last_result   = olast_q;

  // Saturating count after the current candidate beat, and the finish length,
  // which is max_count clipped to the list capacity and to the list fill.
  assign run_new   = (hit_now && run_q != tok_pkg::CNT_SAT) ? run_q + 8'd1 : run_q;
  assign max_lim   = (max_q > tok_pkg::MAXC_W'(tok_pkg::TOP_K)) ?
                     tok_pkg::MAXC_W'(tok_pkg::TOP_K) : max_q;
  assign n_lim     = (tok_pkg::TFW'(max_lim) > tfill_q) ? tfill_q : tok_pkg::TFW'(max_lim);
  assign ins_m1    = ins_q - tok_pkg::TFW'(1);
  assign tfill_inc = (tfill_q != tok_pkg::TFW'(tok_pkg::TOP_K)) ?
                     tfill_q + tok_pkg::TFW'(1) : tfill_q;

  // The scan ends either on a match or once every filled entry has been compared.
  assign scan_end = ((state_q == tok_pkg::S_SCAN_RD) && (idx_q == qfill_q)) ||
                    ((state_q == tok_pkg::S_SCAN_CMP) && (q_rdata == tag_q));
  assign hit_now  = (state_q == tok_pkg::S_SCAN_CMP) && (q_rdata == tag_q);

  always_comb begin
    state_d = state_q;
    qfill_d = qfill_q;
    idx_d   = idx_q;
    excl_d  = excl_q;
    run_d   = run_q;
    tfill_d = tfill_q;
    ins_d   = ins_q;
    icnt_d  = icnt_q;
    fin_n_d = fin_n_q;
    fin_k_d = fin_k_q;
    ovalid_d = ovalid_q && !out_o.ready;
    oid_d   = oid_q;
    ocnt_d  = ocnt_q;
    orv_d   = orv_q;
    olast_d = olast_q;
    q_we    = 1'b0;
    q_waddr = qfill_q[tok_pkg::QAW-1:0];
    q_raddr = idx_q[tok_pkg::QAW-1:0];
    t_we    = 1'b0;
    t_waddr = ins_q[tok_pkg::TAW-1:0];
    t_wdata = {id_q, icnt_q};
    t_raddr = ins_m1[tok_pkg::TAW-1:0];

    case (state_q)
      tok_pkg::S_IDLE: begin
        if (in_acc) begin
          case (tok_pkg::cmd_e'(in_i.cmd))
            tok_pkg::CMD_START: begin
              qfill_d = '0;
              tfill_d = '0;
              run_d   = '0;
              excl_d  = in_i.entity_id;
            end
            tok_pkg::CMD_FINISH: begin
              fin_n_d = n_lim;
              fin_k_d = '0;
              state_d = tok_pkg::S_FIN_RD;
            end
            default: begin
              idx_d   = '0;
              state_d = tok_pkg::S_SCAN_RD;
            end
          endcase
        end
      end

      tok_pkg::S_SCAN_RD, tok_pkg::S_SCAN_CMP: begin
        if (scan_end) begin
          state_d = tok_pkg::S_IDLE;
          if (tok_pkg::cmd_e'(cmd_q) == tok_pkg::CMD_QUERY) begin
            // A new tag is appended only if absent and there is room left.
            if (!hit_now && qfill_q != tok_pkg::QFW'(tok_pkg::QUERY_TAGS)) begin
              q_we    = 1'b1;
              qfill_d = qfill_q + tok_pkg::QFW'(1);
            end
          end else if (last_q) begin
            run_d = '0;
            if (run_new != '0 && id_q != excl_q) begin
              icnt_d  = run_new;
              ins_d   = tfill_q;
              state_d = tok_pkg::S_INS_RD;
            end
          end else begin
            run_d = run_new;
          end
        end else if (state_q == tok_pkg::S_SCAN_RD) begin
          state_d = tok_pkg::S_SCAN_CMP;
        end else begin
          idx_d   = idx_q + tok_pkg::QFW'(1);
          state_d = tok_pkg::S_SCAN_RD;
        end
      end

      // Insertion walks from the tail towards the head, shifting each lower-count
      // entry down by one; an equal count stays ahead of the newcomer.
      tok_pkg::S_INS_RD: begin
        if (ins_q == '0) begin
          t_we    = 1'b1;
          tfill_d = tfill_inc;
          state_d = tok_pkg::S_IDLE;
        end else begin
          state_d = tok_pkg::S_INS_CMP;
        end
      end

      tok_pkg::S_INS_CMP: begin
        if (t_rdata[tok_pkg::CNT_W-1:0] >= icnt_q) begin
          t_we    = (ins_q != tok_pkg::TFW'(tok_pkg::TOP_K));
          tfill_d = tfill_inc;
          state_d = tok_pkg::S_IDLE;
        end else begin
          t_we    = (ins_q != tok_pkg::TFW'(tok_pkg::TOP_K));
          t_wdata = t_rdata;
          ins_d   = ins_m1;
          state_d = tok_pkg::S_INS_RD;
        end
      end

      tok_pkg::S_FIN_RD: begin
        t_raddr = fin_k_q[tok_pkg::TAW-1:0];
        if (max_q == '0) begin
          state_d = tok_pkg::S_IDLE;
        end else if (fin_n_q == '0) begin
          if (out_free) begin
            ovalid_d = 1'b1;
            oid_d    = '0;
            ocnt_d   = '0;
            orv_d    = 1'b0;
            olast_d  = 1'b1;
            state_d  = tok_pkg::S_IDLE;
          end
        end else begin
          state_d = tok_pkg::S_FIN_OUT;
        end
      end

      tok_pkg::S_FIN_OUT: begin
        t_raddr = fin_k_q[tok_pkg::TAW-1:0];
        if (out_free) begin
          ovalid_d = 1'b1;
          oid_d    = t_rdata[tok_pkg::ENTRY_W-1:tok_pkg::CNT_W];
          ocnt_d   = t_rdata[tok_pkg::CNT_W-1:0];
          orv_d    = 1'b1;
          olast_d  = (fin_k_q + tok_pkg::TFW'(1) == fin_n_q);
          fin_k_d  = fin_k_q + tok_pkg::TFW'(1);
          state_d  = olast_d ? tok_pkg::S_IDLE : tok_pkg::S_FIN_RD;
        end
      end

      default: begin
        state_d = tok_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tok_pkg::S_IDLE;
      qfill_q  <= '0;
      excl_q   <= '0;
      run_q    <= '0;
      tfill_q  <= '0;
      max_q    <= tok_pkg::MAX_COUNT_RST;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      qfill_q  <= qfill_d;
      excl_q   <= excl_d;
      run_q    <= run_d;
      tfill_q  <= tfill_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  // Payload and loop registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= in_i.cmd;
      id_q   <= in_i.entity_id;
      tag_q  <= {in_i.tag_kind, in_i.tag_key};
      last_q <= in_i.last_tag;
    end
    idx_q   <= idx_d;
    ins_q   <= ins_d;
    icnt_q  <= icnt_d;
    fin_n_q <= fin_n_d;
    fin_k_q <= fin_k_d;
    oid_q   <= oid_d;
    ocnt_q  <= ocnt_d;
    orv_q   <= orv_d;
    olast_q <= olast_d;
  end

endmodule

>>> rtl/core/tok_checker.sv
// Port-level checker for the tag overlap top-k core, bound to the top level.
// Depends on tok_pkg and on the ports of tag_overlap_top_k_core.
`timescale 1ns / 1ps
module tok_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_cmd_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_id_i,
  input logic [7:0]  out_cnt_i,
  input logic        out_rv_i,
  input logic        out_last_i
);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_id_i) && $stable(out_cnt_i)
      && $stable(out_rv_i) && $stable(out_last_i))
    else $error("stalled result beat changed");

  // The empty-list marker is a lone, all-zero final beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_rv_i |-> out_last_i && out_id_i == '0 && out_cnt_i == '0)
    else $error("malformed empty-list beat");

  // A ranked entry always has a nonzero overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_rv_i |-> out_cnt_i != '0)
    else $error("ranked entry with zero overlap");

  // A finish beat always keeps the input side busy for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_cmd_i == tok_pkg::CMD_FINISH |=> !in_ready_i)
    else $error("input taken straight after finish");

endmodule

bind tag_overlap_top_k_core tok_checker u_tok_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_cmd_i    (in_i.cmd),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_id_i    (out_o.result_id),
  .out_cnt_i   (out_o.overlap_count),
  .out_rv_i    (out_o.result_valid),
  .out_last_i  (out_o.last_result)
);

>>> test/tb_tag_overlap_top_k_core.sv
// Self-checking testbench for the tag overlap top-k core: a table of directed beats,
// then random query/candidate/finish sessions, checked against a behavioural predictor.
// Depends on tok_pkg, tok_if and tag_overlap_top_k_core.
`timescale 1ns / 1ps
module tb_tag_overlap_top_k_core;

  // One input beat as the predictor and the stimulus table see it.
  typedef struct packed {
    tok_pkg::cmd_e cmd;
    logic [31:0]   entity_id;
    logic [1:0]    tag_kind;
    logic [31:0]   tag_key;
    logic          last_tag;
  } beat_t;

  // One result beat.
  typedef struct packed {
    logic [31:0] result_id;
    logic [7:0]  overlap_count;
    logic        result_valid;
    logic        last_result;
  } rank_t;

  // A row of the directed table; has_rank marks rows whose result is typed in.
  typedef struct packed {
    beat_t beat;
    logic  has_rank;
    rank_t rank;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [tok_pkg::MAXC_W-1:0] cfg_wdata_i;

  tok_in_if  in_ch ();
  tok_out_if out_ch ();

  tag_overlap_top_k_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch.sink),
    .out_o       (out_ch.source)
  );

  // Predictor state: its own copy of the query set, the ranked list and the register.
  logic [33:0] qset [tok_pkg::QUERY_TAGS];
  int unsigned qfill;
  logic [31:0] excl_id;
  int unsigned run_cnt;
  logic [31:0] rank_ids [tok_pkg::TOP_K];
  logic [7:0]  rank_cnts [tok_pkg::TOP_K];
  int unsigned rank_fill;
  int unsigned max_results;

  rank_t ranks_due [$];   // expected result beats, oldest first
  int    n_fail;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Whole-run guard: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit query_hit(logic [33:0] tag);
    for (int i = 0; i < qfill; i++)
      if (qset[i] == tag) return 1'b1;
    return 1'b0;
  endfunction

  // Insert after all entries with an equal or higher count, so that ties keep
  // arrival order; a full list drops its tail only when the newcomer beats it.
  function automatic void rank_insert(logic [31:0] id, int unsigned cnt);
    int unsigned pos;
    int unsigned i;
    pos = 0;
    while (pos < rank_fill && rank_cnts[pos] >= cnt) pos++;
    if (pos >= tok_pkg::TOP_K) return;
    i = (rank_fill < tok_pkg::TOP_K) ? rank_fill : tok_pkg::TOP_K - 1;
    while (i > pos) begin
      rank_ids[i]  = rank_ids[i-1];
      rank_cnts[i] = rank_cnts[i-1];
      i--;
    end
    rank_ids[pos]  = id;
    rank_cnts[pos] = cnt[7:0];
    if (rank_fill < tok_pkg::TOP_K) rank_fill++;
  endfunction

  // Advances the predictor by one accepted beat and queues what it should emit.
  function automatic void predict_ranks(beat_t b);
    logic [33:0] tag;
    int unsigned n;
    rank_t r;
    tag = {b.tag_kind, b.tag_key};
    case (b.cmd)
      tok_pkg::CMD_START: begin
        qfill = 0;
        rank_fill = 0;
        run_cnt = 0;
        excl_id = b.entity_id;
      end
      tok_pkg::CMD_QUERY: begin
        if (qfill < tok_pkg::QUERY_TAGS && !query_hit(tag)) begin
          qset[qfill] = tag;
          qfill++;
        end
      end
      tok_pkg::CMD_CAND: begin
        if (query_hit(tag) && run_cnt < 255) run_cnt++;
        if (b.last_tag) begin
          if (run_cnt != 0 && b.entity_id != excl_id) rank_insert(b.entity_id, run_cnt);
          run_cnt = 0;
        end
      end
      default: begin
        if (max_results != 0) begin
          n = (max_results > tok_pkg::TOP_K) ? tok_pkg::TOP_K : max_results;
          if (n > rank_fill) n = rank_fill;
          if (n == 0) begin
            r = '{result_id: '0, overlap_count: '0, result_valid: 1'b0, last_result: 1'b1};
            ranks_due.insert(ranks_due.size(), r);
          end
          for (int k = 0; k < n; k++) begin
            r.result_id     = rank_ids[k];
            r.overlap_count = rank_cnts[k];
            r.result_valid  = 1'b1;
            r.last_result   = (k + 1 == n);
            ranks_due.insert(ranks_due.size(), r);
          end
        end
      end
    endcase
  endfunction

  // Result side: random stalls before each beat, and a field-by-field check of each beat.
  initial begin
    int unsigned stall;
    rank_t got, want;
    out_ch.ready = 1'b0;
    n_fail = 0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      got = '{out_ch.result_id, out_ch.overlap_count, out_ch.result_valid, out_ch.last_result};
      if (ranks_due.size() == 0) begin
        $error("result beat with nothing expected: id %0h count %0d", got.result_id,
               got.overlap_count);
        n_fail++;
      end else begin
        want = ranks_due.pop_front();
        if (got.result_id !== want.result_id) begin
          $error("result_id: expected %0h, got %0h", want.result_id, got.result_id);
          n_fail++;
        end
        if (got.overlap_count !== want.overlap_count) begin
          $error("overlap_count: expected %0d, got %0d", want.overlap_count, got.overlap_count);
          n_fail++;
        end
        if (got.result_valid !== want.result_valid) begin
          $error("result_valid: expected %0b, got %0b", want.result_valid, got.result_valid);
          n_fail++;
        end
        if (got.last_result !== want.last_result) begin
          $error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
          n_fail++;
        end
      end
    end
  end

  // Sends one beat after a random gap; the predictor runs as the beat is accepted.
  // Valid stays up after acceptance only until the caller either sends the next beat
  // or drops it before waiting.
  task automatic send_beat(beat_t b);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= b.cmd;
    in_ch.entity_id <= b.entity_id;
    in_ch.tag_kind  <= b.tag_kind;
    in_ch.tag_key   <= b.tag_key;
    in_ch.last_tag  <= b.last_tag;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_ranks(b);
  endtask

  // A register write is only made with the core idle: the result queue drained and
  // enough slack for the longest scan and candidate close.
  task automatic write_max(logic [tok_pkg::MAXC_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (ranks_due.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    max_results = v;
  endtask

  function automatic beat_t mk(tok_pkg::cmd_e c, logic [31:0] id, logic [1:0] kind,
                               logic [31:0] key, logic last);
    beat_t b;
    b.cmd = c; b.entity_id = id; b.tag_kind = kind; b.tag_key = key; b.last_tag = last;
    return b;
  endfunction

  // Random tags come from a small pool so that candidates really overlap the query;
  // now and then a full-range key exercises every bit.
  function automatic beat_t rand_tag(tok_pkg::cmd_e c, logic [31:0] id, logic last);
    logic [31:0] key;
    key = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 23);
    return mk(c, id, 2'($urandom_range(0, 3)), key, last);
  endfunction

  // A well-formed session: start, query tags, some candidates, a finish.
  task automatic run_session(int unsigned n_cands, int unsigned n_query);
    logic [31:0] excl;
    logic [31:0] cid;
    int unsigned ntags;
    excl = $urandom_range(0, 15);
    send_beat(mk(tok_pkg::CMD_START, excl, 2'd0, 32'd0, 1'b0));
    repeat (n_query) send_beat(rand_tag(tok_pkg::CMD_QUERY, $urandom(), 1'b0));
    repeat (n_cands) begin
      cid = ($urandom_range(0, 7) == 0) ? excl : $urandom();
      ntags = $urandom_range(1, 4);
      for (int t = 0; t < ntags; t++)
        send_beat(rand_tag(tok_pkg::CMD_CAND, cid, t + 1 == ntags));
    end
    send_beat(mk(tok_pkg::CMD_FINISH, $urandom(), 2'($urandom_range(0, 3)), $urandom(),
                 1'($urandom())));
  endtask

  row_t dir_rows [$];

  initial begin
    row_t row;
    rank_t none_r;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = tok_pkg::CMD_START;
    in_ch.entity_id = '0;
    in_ch.tag_kind = '0;
    in_ch.tag_key = '0;
    in_ch.last_tag = 1'b0;
    qfill = 0; excl_id = '0; run_cnt = 0; rank_fill = 0;
    max_results = tok_pkg::MAX_COUNT_RST;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Typed-in results: the empty finish right after reset, and a
    // one-entry run with an id one below the maximum.
    none_r = '{result_id: '0, overlap_count: '0, result_valid: 1'b0, last_result: 1'b1};
    dir_rows = '{
      '{mk(tok_pkg::CMD_FINISH, 32'd0, 2'd0, 32'd0, 1'b0), 1'b1, none_r},
      '{mk(tok_pkg::CMD_START, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF, 1'b1), 1'b0, '0},
      '{mk(tok_pkg::CMD_QUERY, 32'd0, 2'd3, 32'hFFFF_FFFF, 1'b0), 1'b0, '0},
      '{mk(tok_pkg::CMD_QUERY, 32'd0, 2'd3, 32'hFFFF_FFFF, 1'b0), 1'b0, '0}, // duplicate tag
      '{mk(tok_pkg::CMD_QUERY, 32'd0, 2'd0, 32'd0, 1'b0), 1'b0, '0},
      '{mk(tok_pkg::CMD_CAND, 32'd5, 2'd3, 32'hFFFF_FFFF, 1'b0), 1'b0, '0},
      '{mk(tok_pkg::CMD_CAND, 32'd5, 2'd3, 32'hFFFF_FFFF, 1'b0), 1'b0, '0},  // duplicates count
      '{mk(tok_pkg::CMD_CAND, 32'hFFFF_FFFE, 2'd0, 32'd0, 1'b1), 1'b0, '0},  // id from last tag
      '{mk(tok_pkg::CMD_CAND, 32'hFFFF_FFFF, 2'd0, 32'd0, 1'b1), 1'b0, '0},  // excluded id
      '{mk(tok_pkg::CMD_CAND, 32'd7, 2'd1, 32'd0, 1'b1), 1'b0, '0},          // zero count
      '{mk(tok_pkg::CMD_FINISH, 32'd0, 2'd0, 32'd0, 1'b0), 1'b1,
        '{32'hFFFF_FFFE, 8'd3, 1'b1, 1'b1}},
      '{mk(tok_pkg::CMD_CAND, 32'd9, 2'd0, 32'd0, 1'b0), 1'b0, '0},
      '{mk(tok_pkg::CMD_FINISH, 32'd0, 2'd0, 32'd0, 1'b0), 1'b0, '0},        // mid-candidate
      '{mk(tok_pkg::CMD_CAND, 32'd9, 2'd0, 32'd0, 1'b1), 1'b0, '0},          // closes with 2, goes behind
      '{mk(tok_pkg::CMD_CAND, 32'd11, 2'd3, 32'hFFFF_FFFF, 1'b1), 1'b0, '0},
      '{mk(tok_pkg::CMD_FINISH, 32'd0, 2'd0, 32'd0, 1'b0), 1'b0, '0},
      '{mk(tok_pkg::CMD_CAND, 32'd12, 2'd0, 32'd0, 1'b0), 1'b0, '0},
      '{mk(tok_pkg::CMD_START, 32'd3, 2'd0, 32'd0, 1'b0), 1'b0, '0},         // clears the count
      '{mk(tok_pkg::CMD_CAND, 32'd12, 2'd0, 32'd0, 1'b1), 1'b0, '0},
      '{mk(tok_pkg::CMD_FINISH, 32'd0, 2'd0, 32'd0, 1'b0), 1'b0, '0}
    };
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.has_rank) begin
        if (ranks_due.size() != 0) begin
          in_ch.valid <= 1'b0;
          while (ranks_due.size() != 0) @(posedge clk_i);
        end
        send_beat(row.beat);
        // The typed-in row must agree with the predictor before it is trusted.
        if (ranks_due.size() == 0 || ranks_due[ranks_due.size()-1] !== row.rank) begin
          $error("directed row %0d: expected %p, predicted %p", i, row.rank,
                 ranks_due[ranks_due.size()-1]);
          n_fail++;
        end
      end else begin
        send_beat(row.beat);
      end
    end

    // One long session with max_count above the list capacity: a query set filled past
    // its capacity, a candidate whose count saturates, and a top list filled past full.
    write_max(7'd127);
    send_beat(mk(tok_pkg::CMD_START, 32'd1, 2'd0, 32'd0, 1'b0));
    for (int q = 0; q < 65; q++)
      send_beat(mk(tok_pkg::CMD_QUERY, 32'd0, 2'd1, 32'(q), 1'b0));
    for (int t = 0; t < 256; t++)
      send_beat(mk(tok_pkg::CMD_CAND, 32'd77, 2'd1, 32'd0, t == 255));
    for (int c = 0; c < 63; c++)
      send_beat(mk(tok_pkg::CMD_CAND, 32'(c + 100), 2'd1, 32'($urandom_range(0, 63)), 1'b1));
    // Beats the tail of the full list, then one that ties it and one on the dropped tag.
    send_beat(mk(tok_pkg::CMD_CAND, 32'd300, 2'd1, 32'd3, 1'b0));
    send_beat(mk(tok_pkg::CMD_CAND, 32'd300, 2'd1, 32'd5, 1'b1));
    send_beat(mk(tok_pkg::CMD_CAND, 32'd301, 2'd1, 32'd7, 1'b1));
    send_beat(mk(tok_pkg::CMD_CAND, 32'd302, 2'd1, 32'd64, 1'b1));
    send_beat(mk(tok_pkg::CMD_FINISH, 32'd0, 2'd0, 32'd0, 1'b0));

    // Random phases across register settings, zero among them.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: write_max(7'd0);
        1: write_max(7'd1);
        2: write_max(7'd5);
        3: write_max(7'd100);
        default: write_max(7'($urandom_range(0, 127)));
      endcase
      if ($urandom_range(0, 5) == 0)
        // Noise: beats of any command with random content.
        repeat (4) send_beat(mk(tok_pkg::cmd_e'($urandom_range(0, 3)), $urandom_range(0, 15),
                                2'($urandom()), $urandom_range(0, 23), 1'($urandom())));
      else
        run_session($urandom_range(0, 3), $urandom_range(0, 4));
    end

    // Drain and settle, then report.
    in_ch.valid <= 1'b0;
    while (ranks_due.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (n_fail == 0 && ranks_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/core/tok_pkg.sv
rtl/core/tok_if.sv
rtl/core/tok_ram.sv
rtl/core/tag_overlap_top_k_core.sv
rtl/core/tok_checker.sv
test/tb_tag_overlap_top_k_core.sv
